[src/pra_pkg.sv]
// Shared codes for the page replacement block: state encoding, item codes,
// register indexes and the cell update command. No dependencies.
`default_nettype none
package pra_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_RESTART
  } upd_kind_t;

  localparam logic OP_REF     = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  localparam int            CFG_IDX_W = 2;
  localparam int            CFG_DAT_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 2'd1;

  localparam logic [3:0]  FRAMES_RESET = 4'd8;
  localparam int          COUNT_W      = 16;
  localparam int          FIDX_W       = 3;

endpackage
`default_nettype wire

[src/pra_cell.sv]
// One page frame cell: holds page, valid bit and recency rank, folds itself
// into the scan carry from its left neighbor. Depends on pra_pkg.
`default_nettype none
module pra_cell #(
  parameter int  FRAMES    = 8,
  parameter int  PAGE_BITS = 16,
  parameter int  CELL_ID   = 0,
  parameter type scan_t    = logic,
  parameter type bcast_t   = logic,
  parameter type upd_t     = logic
) (
  input  logic   clk,
  input  logic   rst,
  input  bcast_t item,
  input  scan_t  carry_in,
  output scan_t  carry_out,
  input  upd_t   upd
);
  import pra_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [IW-1:0] MY_IDX   = IW'(CELL_ID);
  localparam logic [CW-1:0] MY_POS   = CW'(CELL_ID);
  localparam logic [RW-1:0] RANK_TOP = RW'(FRAMES - 1);

  logic [PAGE_BITS-1:0] page;
  logic                 valid;
  logic [RW-1:0]        rank;
  logic                 active;
  scan_t                carry_next;

  assign active = MY_POS < item.n;

  always_comb begin
    carry_next = carry_in;
    if (active) begin
      if (!carry_in.hit_found && valid && page == item.pg) begin
        carry_next.hit_found = 1'b1;
        carry_next.hit_idx   = MY_IDX;
        carry_next.hit_rank  = rank;
      end
      if (!carry_in.empty_found && !valid) begin
        carry_next.empty_found = 1'b1;
        carry_next.empty_idx   = MY_IDX;
      end
      if (CELL_ID == 0 || rank > carry_in.best_rank) begin
        carry_next.best_rank = rank;
        carry_next.best_idx  = MY_IDX;
        carry_next.best_page = page;
      end
      if (item.ptr == MY_IDX) begin
        carry_next.sel_valid = valid;
        carry_next.sel_page  = page;
        carry_next.sel_rank  = rank;
      end
    end
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      case (upd.kind)
        UPD_RESTART: begin
          valid <= 1'b0;
          rank  <= '0;
        end
        UPD_TOUCH: begin
          if (active) begin
            if (upd.f == MY_IDX) begin
              rank <= '0;
              if (upd.fault) begin
                valid <= 1'b1;
              end
            end else if (valid && (!upd.was_valid || rank < upd.old_rank) &&
                         rank < RANK_TOP) begin
              rank <= rank + RW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (upd.kind == UPD_TOUCH && upd.fault && active && upd.f == MY_IDX) begin
      page <= item.pg;
    end
  end

endmodule
`default_nettype wire

[src/page_replacement_fifo_lru_top.sv]
// Page replacement unit with FIFO and LRU policies.
// A page reference is accepted in the idle state; a scan carry then walks the
// row of frame cells one cell per cycle, then the apply state waits while the
// output is stalled. A restart item skips the walk and goes straight to apply.
// Synchronous reset clears valid bits, ranks, pointer, fault count, state and
// out_valid, and sets the policy and frame count registers to their defaults.
`default_nettype none
module page_replacement_fifo_lru_top #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [PAGE_BITS-1:0]              page,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic [pra_pkg::FIDX_W-1:0]        frame_index,
  output logic                              evicted_valid,
  output logic [PAGE_BITS-1:0]              evicted_page,
  output logic [pra_pkg::COUNT_W-1:0]       fault_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pra_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import pra_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RW = IW;
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [CW-1:0] SCAN_LAST = CW'(FRAMES - 1);

  typedef struct packed {
    logic                 hit_found;
    logic [IW-1:0]        hit_idx;
    logic [RW-1:0]        hit_rank;
    logic                 empty_found;
    logic [IW-1:0]        empty_idx;
    logic [RW-1:0]        best_rank;
    logic [IW-1:0]        best_idx;
    logic [PAGE_BITS-1:0] best_page;
    logic                 sel_valid;
    logic [PAGE_BITS-1:0] sel_page;
    logic [RW-1:0]        sel_rank;
  } scan_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] pg;
    logic [IW-1:0]        ptr;
    logic [CW-1:0]        n;
  } bcast_t;

  typedef struct packed {
    upd_kind_t     kind;
    logic          fault;
    logic [IW-1:0] f;
    logic          was_valid;
    logic [RW-1:0] old_rank;
  } upd_t;

  state_t state, state_next;

  logic                policy;
  logic [3:0]          frames_in_use;
  logic [IW-1:0]       fifo_ptr;
  logic [COUNT_W-1:0]  fault_total;
  logic                op_q;
  bcast_t              item;
  logic [CW-1:0]       scan_cnt;
  logic [CW-1:0]       n_calc;
  logic [IW-1:0]       ptr_calc;
  logic                accept;
  logic                apply_go;

  scan_t               carry [FRAMES+1];
  scan_t               res;
  upd_t                upd;

  logic                d_hit;
  logic                d_fault;
  logic [IW-1:0]       d_f;
  logic                d_was;
  logic [RW-1:0]       d_old;
  logic [PAGE_BITS-1:0] d_ev_page;
  logic [IW-1:0]       ptr_adv;
  logic [IW+2:0]       f_ext;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy        <= POL_FIFO;
      frames_in_use <= FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLICY: policy        <= cfg_data[0];
        CFG_FRAMES: frames_in_use <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (frames_in_use == 4'd0) begin
      n_calc = CW'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      n_calc = CW'(FRAMES);
    end else begin
      n_calc = CW'(frames_in_use);
    end
    ptr_calc = (CW'(fifo_ptr) >= n_calc) ? '0 : fifo_ptr;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (op == OP_RESTART) ? ST_APPLY : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == SCAN_LAST) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    apply_go = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_SCAN:  in_stall = 1'b1;
      ST_APPLY: apply_go = !out_valid || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
    end else begin
      state    <= state_next;
      scan_cnt <= (state == ST_SCAN) ? scan_cnt + CW'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op;
      item.pg  <= page;
      item.ptr <= ptr_calc;
      item.n   <= n_calc;
    end
  end

  assign carry[0] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    pra_cell #(
      .FRAMES   (FRAMES),
      .PAGE_BITS(PAGE_BITS),
      .CELL_ID  (i),
      .scan_t   (scan_t),
      .bcast_t  (bcast_t),
      .upd_t    (upd_t)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .item     (item),
      .carry_in (carry[i]),
      .carry_out(carry[i+1]),
      .upd      (upd)
    );
  end

  assign res = carry[FRAMES];

  always_comb begin
    d_hit     = 1'b0;
    d_fault   = 1'b0;
    d_f       = '0;
    d_was     = 1'b0;
    d_old     = '0;
    d_ev_page = '0;
    if (res.hit_found) begin
      d_hit = 1'b1;
      d_f   = res.hit_idx;
      d_was = 1'b1;
      d_old = res.hit_rank;
    end else begin
      d_fault = 1'b1;
      if (policy == POL_FIFO) begin
        d_f       = item.ptr;
        d_was     = res.sel_valid;
        d_old     = res.sel_rank;
        d_ev_page = res.sel_page;
      end else if (res.empty_found) begin
        d_f = res.empty_idx;
      end else begin
        d_f       = res.best_idx;
        d_was     = 1'b1;
        d_old     = res.best_rank;
        d_ev_page = res.best_page;
      end
    end
    if (!d_was) begin
      d_ev_page = '0;
    end
    ptr_adv = (CW'(item.ptr) + CW'(1) >= item.n) ? '0 : item.ptr + IW'(1);
    f_ext   = {3'b000, d_f};
  end

  always_comb begin
    upd.kind      = UPD_NONE;
    upd.fault     = d_fault;
    upd.f         = d_f;
    upd.was_valid = d_was;
    upd.old_rank  = d_old;
    if (apply_go) begin
      upd.kind = (op_q == OP_RESTART) ? UPD_RESTART : UPD_TOUCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_ptr    <= '0;
      fault_total <= '0;
    end else if (apply_go) begin
      if (op_q == OP_RESTART) begin
        fifo_ptr    <= '0;
        fault_total <= '0;
      end else if (d_fault) begin
        if (policy == POL_FIFO) begin
          fifo_ptr <= ptr_adv;
        end
        if (fault_total != '1) begin
          fault_total <= fault_total + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      if (op_q == OP_RESTART) begin
        hit           <= 1'b0;
        frame_index   <= '0;
        evicted_valid <= 1'b0;
        evicted_page  <= '0;
        fault_count   <= '0;
      end else begin
        hit           <= d_hit;
        frame_index   <= f_ext[2:0];
        evicted_valid <= d_fault && d_was;
        evicted_page  <= d_ev_page;
        fault_count   <= (d_fault && fault_total != '1) ?
                         fault_total + COUNT_W'(1) : fault_total;
      end
    end
  end

  a_restart_skips_scan: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_RESTART |=> state == ST_APPLY)
    else $error("restart did not go straight to apply");

  a_restart_result_zero: assert property (@(posedge clk) disable iff (rst)
    apply_go && op_q == OP_RESTART |=> out_valid && fault_count == '0 && !hit)
    else $error("restart result not cleared");

  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    apply_go && op_q == OP_REF && d_fault && policy == POL_FIFO |=>
      CW'(fifo_ptr) < item.n)
    else $error("fifo pointer beyond frames in use");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit reported with eviction");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    apply_go && op_q == OP_REF |=> fault_total >= $past(fault_total))
    else $error("fault count went down without restart");

endmodule
`default_nettype wire

[tb/sv/tb_page_replacement_fifo_lru_top.sv]
`timescale 1ns / 1ps
// Testbench for page_replacement_fifo_lru_top: directed and random page references under
// both policies and many frame counts, checked against a frame tracker model in a class.
// Depends on pra_pkg and the top-level RTL only.
module tb_page_replacement_fifo_lru_top;
  import pra_pkg::*;

  localparam int NUM_FRAMES = 8;
  localparam int PAGE_W = 16;
  localparam int DRAIN_CYCLES = NUM_FRAMES + 4;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int ONE_FRAME_ITEMS = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] frame_idx;
    logic              ev_valid;
    logic [PAGE_W-1:0] ev_page;
    logic [COUNT_W-1:0] faults;
  } page_result_t;

  class frame_tracker;
    logic [PAGE_W-1:0]  pages [NUM_FRAMES];
    bit                 valid [NUM_FRAMES];
    logic [2:0]         rank  [NUM_FRAMES];
    logic [2:0]         ptr;
    logic [COUNT_W-1:0] faults;
    logic               policy;
    logic [3:0]         nframes;
    page_result_t       pending[$];
    int                 errors;

    function new();
      for (int j = 0; j < NUM_FRAMES; j++) pages[j] = '0;
      restart();
      policy = POL_FIFO;
      nframes = FRAMES_RESET;
      errors = 0;
    endfunction

    function void restart();
      for (int j = 0; j < NUM_FRAMES; j++) begin
        valid[j] = 1'b0;
        rank[j] = '0;
      end
      ptr = '0;
      faults = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_POLICY) policy = data[0];
      else if (idx == CFG_FRAMES) nframes = data;
    endfunction

    function int active_count();
      if (nframes == 0) return 1;
      if (nframes > NUM_FRAMES) return NUM_FRAMES;
      return int'(nframes);
    endfunction

    // make frame f the youngest; frames younger than its old rank age by one
    function void promote(int f, int n, bit was_valid);
      int old;
      old = was_valid ? int'(rank[f]) : NUM_FRAMES;
      for (int j = 0; j < n; j++) begin
        if (j != f && valid[j] && rank[j] < old && rank[j] < NUM_FRAMES - 1)
          rank[j] = rank[j] + 3'd1;
      end
      rank[f] = '0;
    endfunction

    function void note_item(logic o, logic [PAGE_W-1:0] p);
      page_result_t r;
      int n, f, best;
      bit found, empty, was;
      r = '0;
      n = active_count();
      f = 0;
      found = 1'b0;
      empty = 1'b0;
      if (o == OP_RESTART) begin
        restart();
        pending.push_back(r);
        return;
      end
      for (int j = 0; j < n; j++) begin
        if (!found && valid[j] && pages[j] == p) begin
          f = j;
          found = 1'b1;
        end
      end
      if (found) begin
        r.hit = 1'b1;
        promote(f, n, 1'b1);
      end else begin
        if (policy == POL_FIFO) begin
          if (ptr >= n) ptr = '0;
          f = int'(ptr);
          ptr = (ptr + 1 >= n) ? 3'd0 : ptr + 3'd1;
        end else begin
          for (int j = 0; j < n; j++) begin
            if (!empty && !valid[j]) begin
              f = j;
              empty = 1'b1;
            end
          end
          if (!empty) begin
            best = 0;
            f = 0;
            for (int j = 0; j < n; j++) begin
              if (rank[j] > best) begin
                best = rank[j];
                f = j;
              end
            end
            if (rank[0] == best) f = 0;
          end
        end
        was = valid[f];
        if (was) begin
          r.ev_valid = 1'b1;
          r.ev_page = pages[f];
        end
        promote(f, n, was);
        pages[f] = p;
        valid[f] = 1'b1;
        if (faults != '1) faults = faults + 1'b1;
      end
      r.frame_idx = f[FIDX_W-1:0];
      r.faults = faults;
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(page_result_t got);
      page_result_t want;
      if (pending.size() == 0) begin
        report("result transfer with no reference outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("hit got %0h expected %0h", got.hit, want.hit));
      if (got.frame_idx !== want.frame_idx)
        report($sformatf("frame_index got %0d expected %0d", got.frame_idx, want.frame_idx));
      if (got.ev_valid !== want.ev_valid)
        report($sformatf("evicted_valid got %0h expected %0h", got.ev_valid, want.ev_valid));
      if (got.ev_page !== want.ev_page)
        report($sformatf("evicted_page got %0h expected %0h", got.ev_page, want.ev_page));
      if (got.faults !== want.faults)
        report($sformatf("fault_count got %0d expected %0d", got.faults, want.faults));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  logic [PAGE_W-1:0]    page;
  logic                 out_valid;
  logic                 out_stall;
  logic                 hit;
  logic [FIDX_W-1:0]    frame_index;
  logic                 evicted_valid;
  logic [PAGE_W-1:0]    evicted_page;
  logic [COUNT_W-1:0]   fault_count;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  frame_tracker tracker = new();
  int  cycle_count = 0;
  int  hold_cycles = 0;
  bit  sink_quiet = 1'b0;

  page_replacement_fifo_lru_top #(
    .FRAMES   (NUM_FRAMES),
    .PAGE_BITS(PAGE_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .page         (page),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .frame_index  (frame_index),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .fault_count  (fault_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("page_replacement_fifo_lru_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    page_result_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.hit = hit;
        got.frame_idx = frame_index;
        got.ev_valid = evicted_valid;
        got.ev_page = evicted_page;
        got.faults = fault_count;
        tracker.check_result(got);
      end
      if (in_valid && !in_stall) tracker.note_item(op, page);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int run_left;
    int stall_left;
    run_left = 0;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (sink_quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (run_left > 0) begin
        out_stall <= 1'b0;
        run_left--;
      end else begin
        run_left = $urandom_range(0, 15);
        stall_left = pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic o, input logic [PAGE_W-1:0] p, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    page <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic stop_items();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    stop_items();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int frame_plan [16];
    logic [PAGE_W-1:0] pool [16];
    int psize, r, gap;
    bit burst;
    logic pol;

    frame_plan = '{1, 8, 0, 15, 3, 5, 2, 8, 9, 4, 6, 7, 1, 8, 3, 2};
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_REF;
    page = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: FIFO with all frames, fill, hit, evict, restart
    send_item(OP_REF, 16'h0000, 0);
    send_item(OP_REF, 16'hFFFF, pick_gap());
    send_item(OP_REF, 16'h0000, pick_gap());
    for (int k = 2; k < NUM_FRAMES; k++) send_item(OP_REF, PAGE_W'(16'hA5A0 + k), pick_gap());
    send_item(OP_REF, 16'h5A5A, pick_gap());
    send_item(OP_RESTART, 16'hFFFF, pick_gap());
    send_item(OP_REF, 16'h8000, pick_gap());
    settle();

    write_reg(CFG_POLICY, {3'b000, POL_LRU});
    write_reg(CFG_FRAMES, 4'd3);
    write_reg(CFG_SPARE_B, 4'hF);
    write_reg(CFG_SPARE_A, 4'h0);
    send_item(OP_REF, 16'h0001, 0);
    send_item(OP_REF, 16'h0002, pick_gap());
    send_item(OP_REF, 16'h0003, pick_gap());
    send_item(OP_REF, 16'h0001, pick_gap());
    send_item(OP_REF, 16'h0004, pick_gap());
    settle();

    write_reg(CFG_FRAMES, 4'd0);
    send_item(OP_REF, 16'h0007, 0);
    send_item(OP_REF, 16'h0007, pick_gap());
    send_item(OP_REF, 16'h0008, pick_gap());
    settle();

    write_reg(CFG_POLICY, {3'b111, POL_FIFO});
    write_reg(CFG_FRAMES, 4'd15);
    send_item(OP_REF, 16'h0009, 0);
    send_item(OP_REF, 16'h000A, pick_gap());
    settle();

    // random phases over policy and frame count
    for (int k = 0; k < 16; k++) begin
      pol = (k < 4) ? k[0] : logic'($urandom_range(0, 1));
      write_reg(CFG_POLICY, {3'($urandom_range(0, 7)), pol});
      write_reg(CFG_FRAMES, frame_plan[k][3:0]);
      psize = tracker.active_count() + $urandom_range(0, 3);
      for (int j = 0; j < psize; j++) pool[j] = PAGE_W'($urandom_range(0, 65535));
      burst = (k % 5 == 2) || (k == 6);
      sink_quiet = (k % 4 == 1);
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 99);
        gap = burst ? 0 : pick_gap();
        if (r < 2)
          send_item(OP_RESTART, PAGE_W'($urandom_range(0, 65535)), gap);
        else if (r < 14)
          send_item(OP_REF, PAGE_W'($urandom_range(0, 65535)), gap);
        else
          send_item(OP_REF, pool[$urandom_range(0, psize - 1)], gap);
        if (k == 6 && i == 20) hold_cycles = 400;
        if (k == 9 && i == 50) begin
          stop_items();
          while (tracker.pending.size() != 0) @(posedge clk);
        end
      end
      settle();
    end

    // one frame: distinct pages fault and evict the previous page, then a restart and one more reference
    sink_quiet = 1'b1;
    write_reg(CFG_POLICY, {3'b000, POL_FIFO});
    write_reg(CFG_FRAMES, 4'd1);
    for (int i = 0; i < ONE_FRAME_ITEMS; i++) send_item(OP_REF, i[PAGE_W-1:0], 0);
    send_item(OP_REF, 16'h1234, 0);
    send_item(OP_RESTART, 16'h0000, 0);
    send_item(OP_REF, 16'h4321, 0);
    sink_quiet = 1'b0;
    settle();

    if (tracker.errors == 0) begin
      $display("page_replacement_fifo_lru_top verification clean");
    end else begin
      $display("page_replacement_fifo_lru_top verification failed");
    end
    $finish;
  end
endmodule
